// ----- rtl/core/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg : shared types and constants of the linear probe hash table
// Field widths, command and register codes, hash request bundle.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int KEY_W      = 31;
    localparam int MULT_W     = 16;
    localparam int ADD_W      = 16;
    localparam int SIZE_W     = 11;
    localparam int CNT_W      = 11;
    localparam int PROD_W     = MULT_W + KEY_W;     // a * key
    localparam int SUM_W      = PROD_W + 1;         // a * key + c
    localparam int STEP_BITS  = 4;                  // remainder bits per cycle
    localparam int SUM_STEPS  = SUM_W / STEP_BITS;
    localparam int STEP_CNT_W = $clog2(SUM_STEPS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MULT_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_C      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [MULT_W-1:0] mult_a;
        logic [ADD_W-1:0]  add_c;
    } t_hash_req;

endpackage

// ----- rtl/core/lpht_req_if.sv -----
// ----------------------------------------------------------------------------
// lpht_req_if : request channel
// valid/ready channel carrying one command and its key.
// ----------------------------------------------------------------------------
interface lpht_req_if
    import lpht_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [KEY_W-1:0] key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface

// ----- rtl/core/lpht_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lpht_rsp_if : response channel
// valid/ready channel carrying the outcome of one command.
// ----------------------------------------------------------------------------
interface lpht_rsp_if
    import lpht_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             found;
    logic             stored;
    logic [CNT_W-1:0] occupied_count;

    modport source (output valid, output found, output stored, output occupied_count,
                    input ready);
    modport sink   (input valid, input found, input stored, input occupied_count,
                    output ready);
endinterface

// ----- rtl/core/lpht_slot_ram.sv -----
// ----------------------------------------------------------------------------
// lpht_slot_ram : slot store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpht_slot_ram
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [KEY_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [KEY_W-1:0] o_rdata
);
    logic [KEY_W-1:0] r_mem [TABLE_DEPTH];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/lpht_hash.sv -----
// ----------------------------------------------------------------------------
// lpht_hash : home slot unit
// (a*key + c) mod m: one multiply, one add, then a restoring remainder
// taking STEP_BITS dividend bits per cycle.
// ----------------------------------------------------------------------------
module lpht_hash
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int MW = AW + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_hash_req     i_req,
    input  logic [MW-1:0] i_m,       // held stable while busy
    output logic          o_done,
    output logic [AW-1:0] o_home
);
    typedef enum logic [3:0] {
        H_IDLE = 4'b0001,
        H_MUL  = 4'b0010,
        H_ADD  = 4'b0100,
        H_DIV  = 4'b1000
    } t_hstate;

    t_hstate               r_state, n_state;
    t_hash_req             r_req;
    logic [PROD_W-1:0]     r_prod;
    logic [SUM_W-1:0]      r_dvd, n_dvd;
    logic [MW-1:0]         r_rem, n_rem;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic                  r_done;
    logic [MW:0]           trial;

    // STEP_BITS restoring steps; remainder stays below m throughout
    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        trial = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {n_rem, n_dvd[SUM_W-1]};
            n_dvd = {n_dvd[SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, i_m}) begin
                trial = trial - {1'b0, i_m};
            end
            n_rem = trial[MW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            H_IDLE: if (i_start) n_state = H_MUL;
            H_MUL:  n_state = H_ADD;
            H_ADD:  n_state = H_DIV;
            H_DIV:  if (r_cnt == STEP_CNT_W'(SUM_STEPS - 1)) n_state = H_IDLE;
            default: n_state = H_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == H_DIV) && (r_cnt == STEP_CNT_W'(SUM_STEPS - 1));
            if (r_state == H_DIV) begin
                r_cnt <= r_cnt + STEP_CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            H_IDLE: begin
                if (i_start) r_req <= i_req;
            end
            H_MUL: begin
                r_prod <= PROD_W'(r_req.mult_a) * PROD_W'(r_req.key);
            end
            H_ADD: begin
                r_dvd <= SUM_W'(r_prod) + SUM_W'(r_req.add_c);
                r_rem <= '0;
            end
            H_DIV: begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_home = r_rem[AW-1:0];
endmodule

// ----- rtl/core/linear_probe_hash_table.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table : open-addressing hash table, linear probing
// Keys live in one slot RAM; a home slot unit computes (a*key + c) mod m and
// a probe sequencer walks the slots from home, wrapping at m.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  i_req     in   valid/ready        cmd (0 insert, 1 find), key[30:0]
//  o_rsp     out  valid/ready        found, stored, occupied_count[10:0]
//  i_cfg_*   in   write enable only  idx 0 mult_a, 1 add_c, 2 table_size
//
//  Flow: one beat at a time. Home slot: multiply, add, remainder steps of
//  4 bits each, then the done flag. Probing then reads one slot a cycle, up
//  to m probes. Zero key skips both. Then the response register is loaded,
//  waiting while an earlier response is still held on o_rsp.
//  Reset: a clearing pass writes zero to every slot, i_req.ready low
//  meanwhile; config writes are taken throughout.
//  Stalls: a response waiting on o_rsp.ready does not block the next request.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lpht_req_if.sink              i_req,
    lpht_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int MW = AW + 1;                          // holds m up to TABLE_DEPTH
    localparam int CW = (MW > SIZE_W) ? MW : SIZE_W;     // compare width for clamp

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_PROBE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // config registers
    logic [MULT_W-1:0] r_mult_a;
    logic [ADD_W-1:0]  r_add_c;
    logic [SIZE_W-1:0] r_table_size;

    // control
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr_addr;
    logic [CNT_W-1:0]  r_fill;

    // per-beat working state
    logic              r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic [MW-1:0]     r_m;
    logic [AW-1:0]     r_addr;       // next slot to read
    logic [AW-1:0]     r_rd_addr;    // slot whose data is on ram_rdata
    logic              r_rd_vld;
    logic [MW-1:0]     r_iss_left;   // reads still to issue
    logic [MW-1:0]     r_chk_left;   // slots still to check
    logic              r_found;
    logic              r_stored;

    // response register
    logic              r_out_vld;
    logic              r_out_found;
    logic              r_out_stored;
    logic [CNT_W-1:0]  r_out_cnt;

    // RAM side
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [KEY_W-1:0]  ram_rdata;

    // hash unit
    logic              hash_start;
    t_hash_req         hash_req;
    logic              hash_done;
    logic [AW-1:0]     hash_home;

    logic [MW-1:0]     eff_m;
    logic [CW-1:0]     size_ext;
    logic [MW-1:0]     addr_inc;
    logic [AW-1:0]     addr_next;
    logic              in_acc;
    logic              hit;
    logic              last_chk;
    logic              out_load;
    logic              clr_last;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult_a     <= MULT_W'(1);
            r_add_c      <= '0;
            r_table_size <= SIZE_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MULT_A:     r_mult_a     <= i_cfg_data[MULT_W-1:0];
                CFG_ADD_C:      r_add_c      <= i_cfg_data[ADD_W-1:0];
                CFG_TABLE_SIZE: r_table_size <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // m of zero acts as one; above TABLE_DEPTH clamps to TABLE_DEPTH
    always_comb begin
        size_ext = CW'(r_table_size);
        if (r_table_size == '0) begin
            eff_m = MW'(1);
        end else if (size_ext > CW'(TABLE_DEPTH)) begin
            eff_m = MW'(TABLE_DEPTH);
        end else begin
            eff_m = size_ext[MW-1:0];
        end
    end

    // --------------------------------------------------------------- handshake
    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc      = i_req.valid && (r_state == S_IDLE);
    assign out_load    = (r_state == S_DONE) && (!r_out_vld || o_rsp.ready);

    // ----------------------------------------------------------------- probing
    // wrap at m, not at TABLE_DEPTH
    assign addr_inc  = {1'b0, r_addr} + MW'(1);
    assign addr_next = (addr_inc == r_m) ? '0 : addr_inc[AW-1:0];

    assign hit      = r_rd_vld && ((r_cmd == CMD_INSERT) ? (ram_rdata == '0)
                                                         : (ram_rdata == r_key));
    assign last_chk = (r_chk_left == MW'(1));
    assign clr_last = (r_clr_addr == AW'(TABLE_DEPTH - 1));

    assign ram_re = (r_state == S_PROBE) && (r_iss_left != '0);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_rd_addr;
        ram_wdata = r_key;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if ((r_state == S_PROBE) && hit && (r_cmd == CMD_INSERT)) begin
            ram_we    = 1'b1;
        end
    end

    assign hash_start      = in_acc && (i_req.key != '0);
    assign hash_req.key    = i_req.key;
    assign hash_req.mult_a = r_mult_a;
    assign hash_req.add_c  = r_add_c;

    // ----------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_req.key == '0) ? S_DONE : S_HASH;
                end
            end
            S_HASH:  if (hash_done) n_state = S_PROBE;
            S_PROBE: if (r_rd_vld && (hit || last_chk)) n_state = S_DONE;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_fill     <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (ram_we && (r_state == S_PROBE)) begin
                r_fill <= r_fill + CNT_W'(1);     // wraps modulo 2048
            end
            r_rd_vld <= ram_re;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd    <= i_req.cmd;
            r_key    <= i_req.key;
            r_m      <= eff_m;
            r_found  <= 1'b0;
            r_stored <= 1'b0;
        end
        if ((r_state == S_HASH) && hash_done) begin
            r_addr     <= hash_home;
            r_iss_left <= r_m;
            r_chk_left <= r_m;
        end
        if (ram_re) begin
            r_rd_addr  <= r_addr;
            r_addr     <= addr_next;
            r_iss_left <= r_iss_left - MW'(1);
        end
        if ((r_state == S_PROBE) && r_rd_vld) begin
            r_chk_left <= r_chk_left - MW'(1);
            if (hit) begin
                r_found  <= (r_cmd == CMD_FIND);
                r_stored <= (r_cmd == CMD_INSERT);
            end
        end
        if (out_load) begin
            r_out_found  <= r_found;
            r_out_stored <= r_stored;
            r_out_cnt    <= r_fill;
        end
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.found          = r_out_found;
    assign o_rsp.stored         = r_out_stored;
    assign o_rsp.occupied_count = r_out_cnt;

    // ----------------------------------------------------------------- units
    lpht_hash #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_req   (hash_req),
        .i_m     (eff_m),
        .o_done  (hash_done),
        .o_home  (hash_home)
    );

    lpht_slot_ram #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );
endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb : regression bench for linear_probe_hash_table
// Drives insert and find commands through the request channel and keeps a
// shadow copy of the slot store and the hash settings. Every response beat is
// checked against the outcome worked out when its command was accepted.
// Directed cases come first, then random traffic over many hash settings.
// ----------------------------------------------------------------------------
module tb;
    import lpht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 20000;  // beat-free cycles before giving up
    localparam int unsigned DRAIN_WAIT  = 1100;   // worst probe walk plus margin

    // one response as the shadow table predicts it
    typedef struct packed {
        logic             found;
        logic             stored;
        logic [CNT_W-1:0] occupied_count;
    } t_table_outcome;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lpht_req_if req_ch ();
    lpht_rsp_if rsp_ch ();

    linear_probe_hash_table #(
        .TABLE_DEPTH (TABLE_DEPTH_DEF)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow state: slot store, fill count and the hash settings in force
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]  slot_copy [TABLE_DEPTH_DEF];
    int unsigned       fill_count;
    logic [MULT_W-1:0] cfg_mult;
    logic [ADD_W-1:0]  cfg_add;
    logic [SIZE_W-1:0] cfg_size;

    t_table_outcome    pending_outcomes [$];   // oldest first
    logic [KEY_W-1:0]  run_keys [$];           // keys stored by the first test and by random inserts
    logic [KEY_W-1:0]  phase_keys [$];         // keys stored under the current hash

    int unsigned items_sent;
    int unsigned settings_applied;
    int unsigned inserts_stored, inserts_dropped, finds_hit, finds_missed;
    int unsigned fail_count;
    int unsigned quiet_cycles;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Idling regimes, switched by how far the run has got: sender idle
    // 38 % / receiver 62 %, then the reverse, then both flat out.
    // ------------------------------------------------------------------
    function automatic int unsigned tx_gap_pct();
        return (items_sent < 550) ? 38 : ((items_sent < 1100) ? 62 : 0);
    endfunction

    function automatic int unsigned rx_stall_pct();
        return (items_sent < 550) ? 62 : ((items_sent < 1100) ? 38 : 0);
    endfunction

    // ------------------------------------------------------------------
    // Shadow table: hash, then a linear walk over the first m slots.
    // An m of zero acts as one, anything past the depth as the depth.
    // Key zero never touches the store.
    // ------------------------------------------------------------------
    function automatic t_table_outcome probe_table(input logic cmd,
                                                   input logic [KEY_W-1:0] key);
        t_table_outcome res;
        int unsigned    m;
        int unsigned    pos;
        int unsigned    n;
        logic [63:0]    hash_sum;
        res = '0;
        m = (cfg_size == '0) ? 1 : ((cfg_size > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF
                                                                  : int'(cfg_size));
        if (key != '0) begin
            // exact arithmetic, no 32-bit wrap
            hash_sum = 64'(cfg_mult) * 64'(key) + 64'(cfg_add);
            pos = 32'(hash_sum % 64'(m));
            for (n = 0; n < m; n++) begin
                if (cmd == CMD_INSERT) begin
                    if (slot_copy[pos] == '0) begin
                        slot_copy[pos] = key;
                        fill_count++;
                        res.stored = 1'b1;
                        break;
                    end
                end else if (slot_copy[pos] == key) begin
                    // find walks past empty slots, only a hit stops it
                    res.found = 1'b1;
                    break;
                end
                pos = (pos + 1 == m) ? 0 : pos + 1;
            end
        end
        res.occupied_count = CNT_W'(fill_count);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Send one command. valid is left high after the beat, so a back to
    // back command never drops and re-raises it in the same step; it is
    // lowered only on a gap or by settle().
    // ------------------------------------------------------------------
    task automatic send_cmd(input logic cmd, input logic [KEY_W-1:0] key,
                            output t_table_outcome outcome);
        while (tx_gap_pct() != 0 && $urandom_range(99) < tx_gap_pct()) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= cmd;
        req_ch.key   <= key;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        // beat taken at this edge: predict against the state it saw
        outcome = probe_table(cmd, key);
        pending_outcomes.push_back(outcome);
        items_sent++;
        if (cmd == CMD_INSERT) begin
            if (outcome.stored) inserts_stored++;
            else inserts_dropped++;
        end else begin
            if (outcome.found) finds_hit++;
            else finds_missed++;
        end
    endtask

    // wait for every outstanding response, then let the pipe go quiet
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write all three registers, one per edge, write enable held high
    task automatic set_hash(input logic [15:0] a, input logic [15:0] c,
                            input logic [15:0] size_word);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MULT_A;
        i_cfg_data <= a;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ADD_C;
        i_cfg_data <= c;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TABLE_SIZE;
        i_cfg_data <= size_word;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_mult = a;
        cfg_add  = c;
        cfg_size = size_word[SIZE_W-1:0];
        phase_keys.delete();
        settings_applied++;
    endtask

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        if ($urandom_range(7) == 0) k = KEY_W'($urandom_range(1023, 1));
        else k = KEY_W'($urandom);
        if (k == '0) k = KEY_W'(1);
        return k;
    endfunction

    // a key that is likely in the table, mostly from the current hash
    function automatic logic [KEY_W-1:0] known_key();
        if (phase_keys.size() != 0 && $urandom_range(99) < 85)
            return phase_keys[$urandom_range(phase_keys.size() - 1)];
        if (run_keys.size() != 0)
            return run_keys[$urandom_range(run_keys.size() - 1)];
        return fresh_key();
    endfunction

    // one random command: fresh inserts, duplicate inserts, finds of
    // known keys, finds of unknown keys (slow, kept rare) and key zero
    task automatic random_beat(input int unsigned miss_pct);
        t_table_outcome   res;
        logic [KEY_W-1:0] k;
        int unsigned      roll;
        roll = $urandom_range(99);
        if (roll < 45) begin
            k = fresh_key();
            send_cmd(CMD_INSERT, k, res);
            if (res.stored) begin
                phase_keys.push_back(k);
                run_keys.push_back(k);
            end
        end else if (roll < 52) begin
            send_cmd(CMD_INSERT, known_key(), res);
        end else if (roll < 97 - miss_pct) begin
            send_cmd(CMD_FIND, known_key(), res);
        end else if (roll < 97) begin
            send_cmd(CMD_FIND, fresh_key(), res);
        end else begin
            send_cmd(logic'($urandom_range(1)), '0, res);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset settings: a = 1, c = 0, m = 1024, so the home slot is key mod 1024
    task automatic test_reset_defaults();
        t_table_outcome res;
        send_cmd(CMD_INSERT, 31'd1, res);
        send_cmd(CMD_INSERT, 31'h7FFF_FFFF, res);   // lands in the top slot
        send_cmd(CMD_INSERT, 31'd1, res);           // duplicate, next slot up
        send_cmd(CMD_INSERT, '0, res);              // zero key: nothing stored
        send_cmd(CMD_FIND, '0, res);
        send_cmd(CMD_FIND, 31'd1, res);
        send_cmd(CMD_FIND, 31'h7FFF_FFFF, res);
        send_cmd(CMD_FIND, 31'd2, res);             // miss after a full walk
        run_keys.push_back(31'd1);
        run_keys.push_back(31'h7FFF_FFFF);
    endtask

    // tiny tables so inserts run out of room and get dropped
    task automatic test_table_full();
        t_table_outcome res;
        settle();
        set_hash(16'hFFFF, 16'hFFFF, 16'd4);
        repeat (4) send_cmd(CMD_INSERT, fresh_key(), res);
        send_cmd(CMD_FIND, 31'h7FFF_FFFF, res);     // sits above m, not probed
        settle();
        set_hash(16'h0000, 16'hFFFF, 16'd0);        // m of zero acts as one
        send_cmd(CMD_INSERT, fresh_key(), res);
        send_cmd(CMD_FIND, 31'd1, res);
        send_cmd(CMD_INSERT, 31'h7FFF_FFFF, res);
    endtask

    // sizes at and past the depth, and a two-slot table
    task automatic test_size_limits();
        t_table_outcome res;
        settle();
        set_hash(16'h0001, 16'h0000, 16'hFFFF);     // 2047 after masking, clamps
        send_cmd(CMD_FIND, 31'h7FFF_FFFF, res);
        send_cmd(CMD_INSERT, 31'h7FFF_FFFF, res);   // home taken, wraps round
        settle();
        set_hash(16'hFFFF, 16'h0000, 16'd1024);
        send_cmd(CMD_INSERT, 31'h5555_5555, res);
        send_cmd(CMD_FIND, 31'h5555_5555, res);
        settle();
        set_hash(16'hFFFF, 16'h0000, 16'd2);
        send_cmd(CMD_INSERT, 31'h2AAA_AAAA, res);
        send_cmd(CMD_FIND, 31'h2AAA_AAAA, res);
    endtask

    // whole table in use with a random hash, few misses as each walks 1024 slots
    task automatic test_full_size();
        logic [15:0] size_word;
        int unsigned pass;
        for (pass = 0; pass < 2; pass++) begin
            size_word = (pass == 0) ? 16'd2047 : 16'd1024;
            settle();
            set_hash(16'($urandom), 16'($urandom), size_word);
            repeat (45) random_beat(3);
        end
    endtask

    // random settings, m growing phase by phase so the store fills gradually;
    // every fifth phase uses a handful of slots to hit full tables again
    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned top;
        logic [15:0] a, c, m;
        for (phase = 0; phase < 24; phase++) begin
            top = (32 + phase * 42 > 1000) ? 1000 : 32 + phase * 42;
            if (phase % 5 == 0) m = 16'($urandom_range(8, 1));
            else m = 16'($urandom_range(top, top / 4 + 1));
            case ($urandom_range(4))
                0:       a = 16'h0000;
                1:       a = 16'hFFFF;
                2:       a = 16'h0001;
                default: a = 16'($urandom);
            endcase
            case ($urandom_range(3))
                0:       c = 16'h0000;
                1:       c = 16'hFFFF;
                default: c = 16'($urandom);
            endcase
            settle();
            set_hash(a, c, m);
            repeat (64) random_beat(12);
        end
    endtask

    // ------------------------------------------------------------------
    // Response side: random back-pressure, and the check of each beat
    // against the oldest outstanding prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct());
    end

    always @(posedge i_clk) begin : check_rsp
        t_table_outcome due;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
                $error("response beat with no command outstanding");
                fail_count++;
            end else begin
                due = pending_outcomes.pop_front();
                if (rsp_ch.found !== due.found) begin
                    $error("found: expected %0d, got %0d", due.found, rsp_ch.found);
                    fail_count++;
                end
                if (rsp_ch.stored !== due.stored) begin
                    $error("stored: expected %0d, got %0d", due.stored, rsp_ch.stored);
                    fail_count++;
                end
                if (rsp_ch.occupied_count !== due.occupied_count) begin
                    $error("occupied_count: expected %0d, got %0d",
                           due.occupied_count, rsp_ch.occupied_count);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: any beat on either channel restarts the count; covers the
    // clearing pass after reset and the longest probe walk many times over
    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $error("no beat for %0d cycles, %0d responses outstanding",
                   quiet_cycles, pending_outcomes.size());
            $display("linear_probe_hash_table regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_MULT_A;
        i_cfg_data     = '0;
        req_ch.valid   = 1'b0;
        req_ch.cmd     = CMD_INSERT;
        req_ch.key     = '0;
        rsp_ch.ready   = 1'b0;
        quiet_cycles   = 0;
        fail_count     = 0;
        items_sent     = 0;
        settings_applied = 0;
        inserts_stored = 0;
        inserts_dropped = 0;
        finds_hit      = 0;
        finds_missed   = 0;
        fill_count     = 0;
        cfg_mult       = 16'd1;
        cfg_add        = 16'd0;
        cfg_size       = SIZE_W'(1024);
        foreach (slot_copy[i]) slot_copy[i] = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first command waits out the clearing pass on ready
        test_reset_defaults();
        test_table_full();
        test_size_limits();
        test_full_size();
        test_random_traffic();

        settle();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d commands over %0d hash settings: %0d inserts stored, %0d dropped",
                 items_sent, settings_applied, inserts_stored, inserts_dropped);
        $display("%0d finds hit, %0d missed; %0d slots occupied at the end",
                 finds_hit, finds_missed, fill_count);
        if (fail_count == 0) begin
            $display("linear_probe_hash_table regression: pass");
        end else begin
            $display("linear_probe_hash_table regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/lpht_pkg.sv
rtl/core/lpht_req_if.sv
rtl/core/lpht_rsp_if.sv
rtl/core/lpht_slot_ram.sv
rtl/core/lpht_hash.sv
rtl/core/linear_probe_hash_table.sv
verif/tb.sv
